FILE: src/assert_macros.svh
// Assertion macros of the stack pop order checker, used by its top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define SPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted (active low).
`define SPC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: src/spc_pkg.sv
// Package of the stack pop order checker: payload types, sequencer states, constants.
package spc_pkg;

    // Width of a pop value and of a stack entry
    localparam int unsigned VAL_W = 9;
    // Width of the next-value-to-push counter (can reach 512)
    localparam int unsigned NTP_W = 10;
    // Reset value of the sequence length register
    localparam logic [VAL_W-1:0] LEN_RESET = 9'd256;

    // Input transaction
    typedef struct packed {
        logic [VAL_W-1:0] pop_value;
        logic             last_in;
    } t_in_item;

    // Output transaction
    typedef struct packed {
        logic sequence_ok;
        logic is_last;
    } t_out_item;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_PUSH,
        S_CMP,
        S_DONE
    } t_state;

endpackage

FILE: src/stack_pop_sequence_checker.sv
// Top level of the stack pop order checker: sequencer, stack control and output register.
//
//  channel  direction  handshake                payload
//  input    in         i_in_valid / o_in_stall  i_in_data  (pop_value, last_in)
//  output   out        o_out_valid / i_out_stall o_out_data (sequence_ok, is_last)
//  config   in         i_cfg_we                 i_cfg_data (sequence_length)
//
//  One transaction at a time; the next is taken once the sequencer is back in idle.
//  Pop of the stack top: idle, evaluate (read issued), compare, done. Value at or
//  above the next value to push: idle, evaluate, push state with one value pushed
//  per cycle through the single stack write port, done. Failed or ignored value: idle, evaluate, done.
//  The result waits in an output register; a stall there holds only the final
//  state of the next transaction. Reset is synchronous, active low, and needs no
//  clearing pass: stack entries are read only after being written.
`include "assert_macros.svh"

module stack_pop_sequence_checker #(
    parameter int unsigned MAX_LEN = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  spc_pkg::t_in_item         i_in_data,
    // output channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output spc_pkg::t_out_item        o_out_data,
    // configuration
    input  logic                      i_cfg_we,
    input  logic [spc_pkg::VAL_W-1:0] i_cfg_data
);

    localparam int unsigned DW  = $clog2(MAX_LEN + 1);
    localparam int unsigned AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int unsigned CAP = (MAX_LEN > 511) ? 511 : MAX_LEN;
    localparam logic [spc_pkg::VAL_W-1:0] CAP_V   = spc_pkg::VAL_W'(CAP);
    localparam logic [DW-1:0]             DEPTH_MAX = DW'(MAX_LEN);

    spc_pkg::t_state            r_state, n_state;
    logic [spc_pkg::VAL_W-1:0]  r_len;
    logic [spc_pkg::VAL_W-1:0]  r_val, n_val;
    logic                       r_last, n_last;
    logic [DW-1:0]              r_depth, n_depth;
    logic [spc_pkg::NTP_W-1:0]  r_ntp, n_ntp;
    logic                       r_ok, n_ok;
    logic                       r_out_valid, n_out_valid;
    spc_pkg::t_out_item         r_out, n_out;

    logic                       w_accept;
    logic [spc_pkg::VAL_W-1:0]  w_len_eff;
    logic [spc_pkg::NTP_W-1:0]  w_val_ext;
    logic [DW-1:0]              w_depth_dec;
    logic                       w_we;
    logic                       w_re;
    logic [spc_pkg::VAL_W-1:0]  w_rdata;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != spc_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign w_val_ext   = {1'b0, r_val};
    assign w_depth_dec = r_depth - DW'(1);

    // Length register, clamped into 1..min(MAX_LEN, 511) when used
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= spc_pkg::LEN_RESET;
        end else if (i_cfg_we) begin
            r_len <= i_cfg_data;
        end
    end

    always_comb begin
        if (r_len == '0) begin
            w_len_eff = spc_pkg::VAL_W'(1);
        end else if (r_len > CAP_V) begin
            w_len_eff = CAP_V;
        end else begin
            w_len_eff = r_len;
        end
    end

    // Stack storage
    spc_stack #(
        .DEPTH (MAX_LEN),
        .AW    (AW)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_depth[AW-1:0]),
        .i_wdata (r_ntp[spc_pkg::VAL_W-1:0]),
        .i_re    (w_re),
        .i_raddr (w_depth_dec[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spc_pkg::S_IDLE;
            r_depth     <= '0;
            r_ntp       <= spc_pkg::NTP_W'(1);
            r_ok        <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_ntp       <= n_ntp;
            r_ok        <= n_ok;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_val  <= n_val;
        r_last <= n_last;
        r_out  <= n_out;
    end

    // Sequencer: next state, stack control and result load
    always_comb begin
        n_state     = r_state;
        n_val       = r_val;
        n_last      = r_last;
        n_depth     = r_depth;
        n_ntp       = r_ntp;
        n_ok        = r_ok;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        w_we        = 1'b0;
        w_re        = 1'b0;

        case (r_state)
            spc_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_val   = i_in_data.pop_value;
                    n_last  = i_in_data.last_in;
                    n_state = spc_pkg::S_EVAL;
                end
            end
            spc_pkg::S_EVAL: begin
                if (!r_ok) begin
                    // already failed: value ignored
                    n_state = spc_pkg::S_DONE;
                end else if (r_val == '0 || r_val > w_len_eff) begin
                    n_ok    = 1'b0;
                    n_state = spc_pkg::S_DONE;
                end else if (w_val_ext >= r_ntp) begin
                    n_state = spc_pkg::S_PUSH;
                end else if (r_depth == '0) begin
                    // pop from an empty stack
                    n_ok    = 1'b0;
                    n_state = spc_pkg::S_DONE;
                end else begin
                    w_re    = 1'b1;
                    n_state = spc_pkg::S_CMP;
                end
            end
            spc_pkg::S_PUSH: begin
                // one value pushed per cycle until the popped value is reached
                if (r_ntp < w_val_ext) begin
                    if (r_depth < DEPTH_MAX) begin
                        w_we    = 1'b1;
                        n_depth = r_depth + DW'(1);
                    end
                    n_ntp = r_ntp + spc_pkg::NTP_W'(1);
                end else begin
                    n_ntp   = w_val_ext + spc_pkg::NTP_W'(1);
                    n_state = spc_pkg::S_DONE;
                end
            end
            spc_pkg::S_CMP: begin
                if (w_rdata != r_val) begin
                    n_ok = 1'b0;
                end else begin
                    n_depth = w_depth_dec;
                end
                n_state = spc_pkg::S_DONE;
            end
            spc_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.sequence_ok = r_ok;
                    n_out.is_last     = r_last;
                    n_out_valid       = 1'b1;
                    if (r_last) begin
                        n_depth = '0;
                        n_ntp   = spc_pkg::NTP_W'(1);
                        n_ok    = 1'b1;
                    end
                    n_state = spc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = spc_pkg::S_IDLE;
            end
        endcase
    end

    // Checks
    `SPC_ASSERT_NXT(a_accept_to_eval, i_clk, i_rst_n, w_accept, r_state == spc_pkg::S_EVAL)
    `SPC_ASSERT_NXT(a_fail_sticks, i_clk, i_rst_n, !r_ok && r_state != spc_pkg::S_DONE, !r_ok)
    `SPC_ASSERT_IMP(a_push_bounded, i_clk, i_rst_n, r_state == spc_pkg::S_PUSH, r_ntp <= w_val_ext)
    `SPC_ASSERT_IMP(a_cmp_nonempty, i_clk, i_rst_n, r_state == spc_pkg::S_CMP, r_depth != '0)

endmodule

FILE: src/spc_stack.sv
// Stack storage of the pop order checker: one write port, one registered read port.
module spc_stack #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = 8
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [spc_pkg::VAL_W-1:0]   i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [spc_pkg::VAL_W-1:0]   o_rdata
);

    logic [spc_pkg::VAL_W-1:0] r_mem [DEPTH];
    logic [spc_pkg::VAL_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
